### hw/rtl/mabt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabt_pkg: shared constants for the matrix E = C*B^T + G core
// Sizes, function codes and result kinds.
// ----------------------------------------------------------------------------
package mabt_pkg;

  localparam int MAX_N  = 16;
  localparam int IDX_W  = $clog2(MAX_N);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = MAX_N * MAX_N;
  localparam int N_W    = IDX_W + 1;

  localparam int ELEM_W = 16;
  localparam int C_W    = 40;
  localparam int E_W    = 64;
  localparam int G_W    = 48;
  localparam int PROD_W = C_W + ELEM_W;

  typedef logic [1:0] func_t;
  typedef logic [1:0] kind_t;

  localparam func_t FUNC_WR_A = 2'd0;
  localparam func_t FUNC_WR_B = 2'd1;
  localparam func_t FUNC_COMP = 2'd2;
  localparam func_t FUNC_RD_E = 2'd3;

  localparam kind_t KIND_ACK  = 2'd0;
  localparam kind_t KIND_COMP = 2'd1;
  localparam kind_t KIND_READ = 2'd2;

endpackage

### hw/rtl/matrix_abbt_plus_ata_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_abbt_plus_ata_core: fixed-point E = C*B^T + G matrix engine
// Loads A and B (Q8.8), computes E (Q40.24, saturating), reads E back.
// ----------------------------------------------------------------------------
// Load transactions are accepted one per cycle while the core is idle and
// the result output is not held back; a read returns its E element in the
// cycle after acceptance, at the same rate. A compute transaction runs on a
// single shared 40x16 multiplier with a read, multiply and accumulate state
// for each product term, and while it runs in_tready is low.
module matrix_abbt_plus_ata_core
  import mabt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,      // n_used
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,       // row[3:0], col[7:4], elem_value[23:8]
  input  logic [1:0]  in_tuser,       // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,      // result_value[63:0], saturated[64], zero pad
  output logic [1:0]  out_tuser       // kind
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CRD  = 4'd1;
  localparam logic [3:0] ST_CMUL = 4'd2;
  localparam logic [3:0] ST_CACC = 4'd3;
  localparam logic [3:0] ST_ERD  = 4'd4;
  localparam logic [3:0] ST_EMUL = 4'd5;
  localparam logic [3:0] ST_EACC = 4'd6;
  localparam logic [3:0] ST_GRD  = 4'd7;
  localparam logic [3:0] ST_GMUL = 4'd8;
  localparam logic [3:0] ST_GACC = 4'd9;

  function automatic logic [E_W:0] sat_add(input logic signed [E_W-1:0] x,
                                           input logic signed [E_W-1:0] y);
    logic signed [E_W-1:0] s;
    logic                  ovf;
    s   = x + y;
    ovf = (x[E_W-1] == y[E_W-1]) && (s[E_W-1] != x[E_W-1]);
    if (ovf) begin
      return {1'b1, x[E_W-1], {(E_W-1){~x[E_W-1]}}};
    end
    return {1'b0, s};
  endfunction

  logic [3:0]               state_r, state_nxt;
  logic [IDX_W-1:0]         i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [E_W-1:0]    acc_r, acc_nxt;
  logic signed [G_W-1:0]    g_r, g_nxt;
  logic                     clip_r, clip_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [N_W-1:0]           n_used_r;
  logic                     out_valid_r, out_valid_nxt;
  kind_t                    out_kind_r, out_kind_nxt;

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  logic signed [C_W-1:0]    c_mem [DEPTH];
  logic signed [E_W-1:0]    e_mem [DEPTH];
  logic [DEPTH-1:0]         sat_r;

  logic signed [ELEM_W-1:0] a_q_r, a2_q_r, b_q_r;
  logic signed [C_W-1:0]    c_q_r;
  logic signed [E_W-1:0]    e_q_r;
  logic                     sat_q_r;

  logic                     in_acc;
  func_t                    func;
  logic [ADDR_W-1:0]        in_addr;
  logic [ADDR_W-1:0]        a_raddr, a2_raddr, b_raddr, c_raddr, ij_addr;
  logic [N_W-1:0]           n_eff;
  logic [IDX_W-1:0]         nm1;
  logic                     last_j, last_i, done_c, done_g;
  logic [IDX_W-1:0]         adv_i, adv_j;
  logic signed [C_W-1:0]    mul_x;
  logic signed [ELEM_W-1:0] mul_y;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [E_W-1:0]    prod_ext, c_sum;
  logic signed [G_W-1:0]    g_sum;
  logic [E_W:0]             e_add, e_fin;
  logic                     c_we, e_we;

  assign func     = in_tuser;
  assign in_addr  = {in_tdata[3:0], in_tdata[7:4]};
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc   = in_tvalid && in_tready;

  assign n_eff = (n_used_r == '0) ? N_W'(1) :
                 (n_used_r > N_W'(MAX_N)) ? N_W'(MAX_N) : n_used_r;
  assign nm1   = IDX_W'(n_eff - N_W'(1));

  assign last_j = (j_r == nm1);
  assign last_i = (i_r == nm1);
  assign adv_j  = last_j ? '0 : j_r + IDX_W'(1);
  assign adv_i  = last_j ? i_r + IDX_W'(1) : i_r;

  assign ij_addr  = {i_r, j_r};
  assign a_raddr  = (state_r == ST_CRD) ? {i_r, k_r} : {k_r, i_r};
  assign a2_raddr = {k_r, j_r};
  assign b_raddr  = (state_r == ST_CRD) ? {k_r, j_r} : {j_r, k_r};
  assign c_raddr  = {i_r, k_r};

  // shared multiplier
  always_comb begin
    case (state_r)
      ST_EMUL: begin
        mul_x = c_q_r;
        mul_y = b_q_r;
      end
      ST_GMUL: begin
        mul_x = C_W'(a_q_r);
        mul_y = a2_q_r;
      end
      default: begin
        mul_x = C_W'(a_q_r);
        mul_y = b_q_r;
      end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  assign prod_ext = E_W'(prod_r);
  assign c_sum    = acc_r + prod_ext;
  assign e_add    = sat_add(acc_r, prod_ext);
  assign g_sum    = g_r + prod_r[G_W-1:0];
  assign e_fin    = sat_add(acc_r, E_W'(g_sum) <<< 8);

  assign done_c = (state_r == ST_CACC) && (k_r == nm1);
  assign done_g = (state_r == ST_GACC) && (k_r == j_r);
  assign c_we   = done_c;
  assign e_we   = done_g;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    g_nxt     = g_r;
    clip_nxt  = clip_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (func == FUNC_COMP) begin
            state_nxt = ST_CRD;
            i_nxt     = '0;
            j_nxt     = '0;
            k_nxt     = '0;
            acc_nxt   = '0;
            g_nxt     = '0;
            clip_nxt  = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = (func == FUNC_RD_E) ? KIND_READ : KIND_ACK;
          end
        end
      end
      ST_CRD:  state_nxt = ST_CMUL;
      ST_CMUL: state_nxt = ST_CACC;
      ST_CACC: begin
        if (k_r == nm1) begin
          acc_nxt = '0;
          j_nxt   = adv_j;
          i_nxt   = adv_i;
          if (last_j && last_i) begin
            state_nxt = ST_ERD;
            i_nxt     = '0;
            j_nxt     = '0;
            k_nxt     = '0;
          end else begin
            state_nxt = ST_CRD;
            k_nxt     = (adv_i >= adv_j) ? adv_i : '0;
          end
        end else begin
          acc_nxt   = c_sum;
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = ST_CRD;
        end
      end
      ST_ERD:  state_nxt = ST_EMUL;
      ST_EMUL: state_nxt = ST_EACC;
      ST_EACC: begin
        acc_nxt  = e_add[E_W-1:0];
        clip_nxt = clip_r | e_add[E_W];
        if (k_r == nm1) begin
          k_nxt     = '0;
          state_nxt = ST_GRD;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = ST_ERD;
        end
      end
      ST_GRD:  state_nxt = ST_GMUL;
      ST_GMUL: state_nxt = ST_GACC;
      ST_GACC: begin
        if (k_r == j_r) begin
          acc_nxt  = '0;
          g_nxt    = '0;
          clip_nxt = 1'b0;
          k_nxt    = '0;
          j_nxt    = adv_j;
          i_nxt    = adv_i;
          if (last_j && last_i) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_COMP;
          end else begin
            state_nxt = ST_ERD;
          end
        end else begin
          g_nxt     = g_sum;
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = ST_GRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_used_r    <= N_W'(MAX_N);
      out_valid_r <= 1'b0;
      out_kind_r  <= KIND_ACK;
      sat_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_kind_r  <= out_kind_nxt;
      if (cfg_we) begin
        n_used_r <= cfg_wdata;
      end
      if (e_we) begin
        sat_r[ij_addr] <= clip_r | e_fin[E_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    g_r    <= g_nxt;
    clip_r <= clip_nxt;
    prod_r <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (in_acc && func == FUNC_WR_A) begin
      a_mem[in_addr] <= in_tdata[23:8];
    end
    a_q_r  <= a_mem[a_raddr];
    a2_q_r <= a_mem[a2_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && func == FUNC_WR_B) begin
      b_mem[in_addr] <= in_tdata[23:8];
    end
    b_q_r <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[ij_addr] <= c_sum[C_W-1:0];
    end
    c_q_r <= c_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      e_mem[ij_addr] <= e_fin[E_W-1:0];
    end
    if (in_acc && func == FUNC_RD_E) begin
      e_q_r   <= e_mem[in_addr];
      sat_q_r <= sat_r[in_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = (out_kind_r == KIND_READ) ?
                      {7'b0, sat_q_r, e_q_r} : 72'b0;

  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func != FUNC_COMP) |=> (out_tvalid && out_tuser != KIND_COMP))
    else $error("load or read transaction without result");

  a_comp_done: assert property (@(posedge clk) disable iff (!rst_n)
    (done_g && last_j && last_i) |=> (out_tvalid && out_tuser == KIND_COMP))
    else $error("compute finished without result");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (k_r <= nm1 && i_r <= nm1 && j_r <= nm1))
    else $error("loop counter beyond dimension");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == FUNC_COMP) |=> (!in_tready && !out_tvalid))
    else $error("compute did not hold off input");

endmodule

### test/tb_matrix_abbt_plus_ata_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_abbt_plus_ata_core: self-checking bench for the E = C*B^T + G core
// Loads A and B, runs computes at several sizes and reads E back. Results
// are predicted in order and compared field by field. Both stream sides
// idle at random, with one long output hold and drain-and-pause points.
// ----------------------------------------------------------------------------
module tb_matrix_abbt_plus_ata_core;
  import mabt_pkg::*;

  localparam int LIMIT = 2000000;

  typedef struct {
    kind_t       kind;
    logic [63:0] value;
    logic        sat;
  } e_result_t;

  class matrix_scoreboard;
    logic signed [15:0] a_mat[DEPTH];
    logic signed [15:0] b_mat[DEPTH];
    longint             c_mat[DEPTH];
    longint             e_mat[DEPTH];
    bit                 sat_mat[DEPTH];
    bit                 e_ok[DEPTH];
    int                 n_used;
    e_result_t          pending[$];
    int                 errors;

    function void clear();
      foreach (sat_mat[i]) begin
        sat_mat[i] = 0;
        e_ok[i]    = 0;
      end
      n_used = 16;
      errors = 0;
    endfunction

    function longint sat_add(longint x, longint y, inout bit clip);
      longint s;
      s = x + y;
      if (x[63] == y[63] && s[63] != x[63]) begin
        clip = 1;
        s    = x[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      end
      return s;
    endfunction

    function void run_compute();
      int     n;
      longint acc, g;
      bit     clip;
      n = (n_used == 0) ? 1 : (n_used > MAX_N ? MAX_N : n_used);
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          acc = 0;
          for (int k = (i >= j) ? i : 0; k < n; k++)
            acc += longint'(a_mat[i*MAX_N+k]) * longint'(b_mat[k*MAX_N+j]);
          c_mat[i*MAX_N+j] = acc;
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          clip = 0;
          acc  = 0;
          g    = 0;
          for (int k = 0; k < n; k++)
            acc = sat_add(acc, c_mat[i*MAX_N+k] * longint'(b_mat[j*MAX_N+k]), clip);
          for (int k = 0; k <= j; k++)
            g += longint'(a_mat[k*MAX_N+i]) * longint'(a_mat[k*MAX_N+j]);
          acc = sat_add(acc, g * 256, clip);
          e_mat[i*MAX_N+j]   = acc;
          sat_mat[i*MAX_N+j] = clip;
          e_ok[i*MAX_N+j]    = 1;
        end
    endfunction

    function void note_input(func_t f, int row, int col, logic signed [15:0] v);
      e_result_t r;
      int        idx;
      idx     = row * MAX_N + col;
      r.kind  = KIND_ACK;
      r.value = '0;
      r.sat   = 0;
      case (f)
        FUNC_WR_A: a_mat[idx] = v;
        FUNC_WR_B: b_mat[idx] = v;
        FUNC_COMP: begin
          run_compute();
          r.kind = KIND_COMP;
        end
        default: begin
          r.kind  = KIND_READ;
          r.value = e_mat[idx];
          r.sat   = sat_mat[idx];
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(kind_t kind, logic [63:0] value, logic sat);
      e_result_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %h", $realtime, kind, value);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (kind !== r.kind) begin
        $display("%0t: kind expected %0d actual %0d", $realtime, r.kind, kind);
        errors++;
      end
      if (value !== r.value) begin
        $display("%0t: value expected %h actual %h", $realtime, r.value, value);
        errors++;
      end
      if (sat !== r.sat) begin
        $display("%0t: saturated expected %0d actual %0d", $realtime, r.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  matrix_scoreboard sb;
  int  cycles;
  int  rx_hold;
  int  rx_wait;
  bit  rx_quiet;
  bit  tx_quiet;

  matrix_abbt_plus_ata_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[63:0], out_tdata[64]);
  end

  // receiver: per-transaction random stall plus an optional long hold
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        if (out_tvalid && out_tready && !rx_quiet)
          rx_wait = $urandom_range(0, 3);
        out_tready <= (rx_wait == 0);
      end
    end
  end

  task automatic send_item(func_t f, int row, int col, logic signed [15:0] v);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {v, col[3:0], row[3:0]};
    do @(posedge clk); while (!in_tready);
    sb.note_input(f, row, col, v);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(int n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n[4:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.n_used = n;
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic read_any();
    int idx;
    do idx = $urandom_range(0, DEPTH - 1); while (!sb.e_ok[idx]);
    send_item(FUNC_RD_E, idx / MAX_N, idx % MAX_N, 16'($urandom()));
  endtask

  task automatic run_phase(int n, int items, int computes);
    int r;
    set_size(n);
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (computes > 0 && r < 3) begin
        send_item(FUNC_COMP, $urandom_range(0, 15), $urandom_range(0, 15),
                  16'($urandom()));
        computes--;
      end else if (r < 45)
        send_item(FUNC_WR_A, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
      else if (r < 75)
        send_item(FUNC_WR_B, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
      else
        read_any();
    end
    if (computes > 0)
      send_item(FUNC_COMP, 0, 0, 16'sh0);
    for (int i = 0; i < 10; i++)
      read_any();
  endtask

  initial begin
    int sizes[14];
    sb        = new();
    sb.clear();
    cycles    = 0;
    rx_hold   = 0;
    rx_wait   = 0;
    rx_quiet  = 0;
    tx_quiet  = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_WR_A;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every A and B entry, extremes in the corners
    for (int i = 0; i < DEPTH; i++) begin
      send_item(FUNC_WR_A, i / MAX_N, i % MAX_N,
                (i == 0) ? 16'sh8000 : (i == DEPTH - 1) ? 16'sh7fff : rand_elem());
      send_item(FUNC_WR_B, i / MAX_N, i % MAX_N,
                (i == 0) ? 16'sh8000 : (i == DEPTH - 1) ? 16'sh7fff : rand_elem());
    end
    // compute at the reset size, read back corners
    send_item(FUNC_COMP, 0, 0, 16'sh0);
    send_item(FUNC_RD_E, 0, 0, 16'sh0);
    send_item(FUNC_RD_E, 15, 15, 16'shffff);
    send_item(FUNC_RD_E, 0, 15, 16'sh0);
    send_item(FUNC_RD_E, 15, 0, 16'sh0);
    drain();

    // all extremes, smallest size
    set_size(1);
    send_item(FUNC_WR_A, 0, 0, 16'sh8000);
    send_item(FUNC_WR_B, 0, 0, 16'sh8000);
    send_item(FUNC_COMP, 0, 0, 16'sh0);
    send_item(FUNC_RD_E, 0, 0, 16'sh0);
    send_item(FUNC_WR_A, 0, 0, 16'sh7fff);
    send_item(FUNC_COMP, 0, 0, 16'sh0);
    send_item(FUNC_RD_E, 0, 0, 16'sh0);
    send_item(FUNC_RD_E, 15, 15, 16'sh0);
    drain();

    // long output hold while the sender keeps going
    rx_hold  = 200;
    tx_quiet = 1;
    for (int i = 0; i < 40; i++)
      read_any();
    tx_quiet = 0;
    drain();

    sizes = '{2, 16, 3, 1, 5, 8, 4, 7, 2, 6, 1, 3, 8, 16};
    foreach (sizes[p]) begin
      rx_quiet = (p % 4 == 2);
      tx_quiet = (p % 4 == 2);
      run_phase(sizes[p], 90, (sizes[p] == 16) ? 1 : 2);
      drain();
    end
    rx_quiet = 0;
    tx_quiet = 0;

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
